// ----- rtl/tcwu_pkg.sv -----
package tcwu_pkg;

    localparam int SEQ_W    = 32;
    localparam int WIN_W    = 32;
    localparam int MSS_W    = 16;
    localparam int DUP_W    = 8;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // s_tdata: unacked_seq, next_send_seq
    localparam int S_TDATA_W = 2 * SEQ_W;
    localparam int S_TUSER_W = 1;
    // m_tdata: window, threshold, resend_from, resend_to
    localparam int M_TDATA_W = 2 * WIN_W + 2 * SEQ_W;
    // m_tuser: phase, retransmit_request
    localparam int M_TUSER_W = PHASE_W + 1;

    localparam logic [PHASE_W-1:0] PH_SS = 2'd0;
    localparam logic [PHASE_W-1:0] PH_CA = 2'd1;
    localparam logic [PHASE_W-1:0] PH_FR = 2'd2;

    localparam logic REQ_NEW_ACK = 1'b0;
    localparam logic REQ_DUP_ACK = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_SIZE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_THRESHOLD = 1'd1;

    localparam logic [DUP_W-1:0] DUP_LIMIT = 8'd3;
    localparam logic [DUP_W-1:0] DUP_MAX   = 8'd255;

    localparam logic [MSS_W-1:0] RESET_MSS    = 16'd1460;
    localparam logic [WIN_W-1:0] RESET_THRESH = 32'd65535;

    localparam logic [WIN_W-1:0] WIN_MAX = '1;

    function automatic logic [WIN_W-1:0] sat_add(input logic [WIN_W-1:0] a,
                                                  input logic [WIN_W-1:0] b);
        logic [WIN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WIN_W] ? WIN_MAX : s[WIN_W-1:0];
    endfunction

    // a before b in modulo-2^32 order
    function automatic logic seq_before(input logic [SEQ_W-1:0] a,
                                        input logic [SEQ_W-1:0] b);
        logic [SEQ_W-1:0] d;
        d = a - b;
        return d[SEQ_W-1];
    endfunction

endpackage

// ----- rtl/tcp_reno_congestion_window_unit.sv -----
// Reno congestion window unit.
// The input word waits in the input register; its result is captured in the result register.
// Throughput: one word per cycle unless the output stalls; a single compare/shift/add pass updates state.
// A stalled result register back-pressures the input register only when both are full.
// Reset (aresetn low, synchronous): phase slow start, window 1460, threshold 65535,
// duplicate count and recovery point zero, both pipeline registers empty.
module tcp_reno_congestion_window_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [tcwu_pkg::S_TDATA_W-1:0]        s_tdata,  // unacked_seq, next_send_seq
    input  logic [tcwu_pkg::S_TUSER_W-1:0]        s_tuser,  // req_type
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [tcwu_pkg::M_TDATA_W-1:0]        m_tdata,  // window, threshold, resend_from, resend_to
    output logic [tcwu_pkg::M_TUSER_W-1:0]        m_tuser,  // phase, retransmit_request
    input  logic                                  cfg_we,
    input  logic [tcwu_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tcwu_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SW = tcwu_pkg::SEQ_W;
    localparam int WW = tcwu_pkg::WIN_W;

    // input register
    logic          in_valid_reg;
    logic          in_dup_reg;
    logic [SW-1:0] in_una_reg;
    logic [SW-1:0] in_nxt_reg;

    // state
    logic [tcwu_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [WW-1:0]                cwnd_reg, cwnd_next;
    logic [WW-1:0]                ssth_reg, ssth_next;
    logic [tcwu_pkg::DUP_W-1:0]   dup_reg, dup_next;
    logic [SW-1:0]                recov_reg, recov_next;
    logic [tcwu_pkg::MSS_W-1:0]   mss_reg;

    // result register
    logic                           out_valid_reg;
    logic [tcwu_pkg::M_TDATA_W-1:0] out_data_reg, out_data_next;
    logic [tcwu_pkg::M_TUSER_W-1:0] out_user_reg, out_user_next;

    logic          advance;
    logic          req;
    logic [SW-1:0] from_v, to_v;
    logic [WW-1:0] mss_w, mss3_w, half_w;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign mss_w  = WW'(mss_reg);
    assign mss3_w = (mss_w << 1) + mss_w;
    assign half_w = cwnd_reg >> 1;

    always_comb begin
        phase_next = phase_reg;
        cwnd_next  = cwnd_reg;
        ssth_next  = ssth_reg;
        dup_next   = dup_reg;
        recov_next = recov_reg;
        req        = 1'b0;
        from_v     = '0;
        to_v       = '0;
        if (in_dup_reg == tcwu_pkg::REQ_NEW_ACK) begin
            dup_next = '0;
            unique case (phase_reg)
                tcwu_pkg::PH_SS: begin
                    if (cwnd_reg <= ssth_reg) begin
                        cwnd_next = tcwu_pkg::sat_add(cwnd_reg, cwnd_reg);
                    end else begin
                        phase_next = tcwu_pkg::PH_CA;
                    end
                end
                tcwu_pkg::PH_CA: begin
                    cwnd_next = tcwu_pkg::sat_add(cwnd_reg, mss_w);
                end
                tcwu_pkg::PH_FR: begin
                    if (tcwu_pkg::seq_before(in_una_reg, recov_reg)) begin
                        req    = 1'b1;
                        from_v = in_una_reg;
                        to_v   = recov_reg;
                    end else begin
                        cwnd_next  = ssth_reg;
                        phase_next = tcwu_pkg::PH_CA;
                    end
                end
                default: ;
            endcase
        end else begin
            if (dup_reg != tcwu_pkg::DUP_MAX) begin
                dup_next = dup_reg + 1'b1;
            end
            unique case (phase_reg) inside
                tcwu_pkg::PH_SS, tcwu_pkg::PH_CA: begin
                    if (dup_next >= tcwu_pkg::DUP_LIMIT) begin
                        ssth_next  = half_w;
                        cwnd_next  = tcwu_pkg::sat_add(half_w, mss3_w);
                        recov_next = in_nxt_reg;
                        phase_next = tcwu_pkg::PH_FR;
                    end
                end
                tcwu_pkg::PH_FR: begin
                    cwnd_next = tcwu_pkg::sat_add(cwnd_reg, mss_w);
                end
                default: ;
            endcase
        end
        out_data_next = {to_v, from_v, ssth_next, cwnd_next};
        out_user_next = {req, phase_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= tcwu_pkg::PH_SS;
            cwnd_reg      <= WW'(tcwu_pkg::RESET_MSS);
            ssth_reg      <= tcwu_pkg::RESET_THRESH;
            dup_reg       <= '0;
            recov_reg     <= '0;
            mss_reg       <= tcwu_pkg::RESET_MSS;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                cwnd_reg      <= cwnd_next;
                ssth_reg      <= ssth_next;
                dup_reg       <= dup_next;
                recov_reg     <= recov_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            // the user must send config only while idle, so it never meets an advance; the block does not enforce this
            if (cfg_we) begin
                unique case (cfg_index)
                    tcwu_pkg::CFG_SEGMENT_SIZE: begin
                        mss_reg  <= cfg_data[tcwu_pkg::MSS_W-1:0];
                        cwnd_reg <= WW'(cfg_data[tcwu_pkg::MSS_W-1:0]);
                    end
                    tcwu_pkg::CFG_INITIAL_THRESHOLD: begin
                        ssth_reg <= cfg_data[WW-1:0];
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_dup_reg <= s_tuser[0];
            in_una_reg <= s_tdata[SW-1:0];
            in_nxt_reg <= s_tdata[2*SW-1:SW];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
            out_user_reg <= out_user_next;
        end
    end

`ifndef SYNTHESIS
    a_retx_in_fr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[tcwu_pkg::PHASE_W] |->
            m_tuser[tcwu_pkg::PHASE_W-1:0] == tcwu_pkg::PH_FR)
        else $error("retransmit request outside fast recovery");

    a_new_ack_clears_dup: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_dup_reg == tcwu_pkg::REQ_NEW_ACK |=> dup_reg == '0)
        else $error("duplicate count not cleared by new ack");

    a_dup_stays_fr: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_dup_reg == tcwu_pkg::REQ_DUP_ACK && phase_reg == tcwu_pkg::PH_FR
            |=> phase_reg == tcwu_pkg::PH_FR)
        else $error("duplicate ack left fast recovery");

    a_empty_takes_word: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("empty input register refuses a word");
`endif

endmodule
